// ----- src/tga_rle_pkg.sv -----
// ----------------------------------------------------------------------------
// tga_rle_pkg
// shared types and constants of the run-length tga pixel stream decoder
// ----------------------------------------------------------------------------
package tga_rle_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PIXEL_W     = 32;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned PB_W        = 3;
    localparam int unsigned TOTAL_W     = 32;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned APB_ADDR_W  = 3;

    localparam logic [BYTE_W-1:0] HDR_COUNT_MASK = 8'h7f;
    localparam logic [BYTE_W-1:0] HDR_RUN_FLAG   = 8'h80;

    localparam logic [PB_W-1:0]    PIXEL_BYTES_RESET  = 3'd3;
    localparam logic [TOTAL_W-1:0] TOTAL_PIXELS_RESET = 32'd0;

    typedef enum logic [0:0] {
        REG_PIXEL_BYTES  = 1'b0,
        REG_TOTAL_PIXELS = 1'b1
    } reg_sel_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_RUN    = 2'd1,
        PH_RAW    = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef struct packed {
        logic               restart;
        logic [PB_W-1:0]    pixel_bytes;
        logic [TOTAL_W-1:0] total_pixels;
    } cfg_t;

endpackage

// ----- src/tga_rle_if.sv -----
// ----------------------------------------------------------------------------
// tga_rle_if
// valid/ready channels for the compressed byte stream and the pixel results
// ----------------------------------------------------------------------------
interface tga_rle_in_if;
    logic                             valid;
    logic                             ready;
    logic [tga_rle_pkg::BYTE_W-1:0]   in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface tga_rle_out_if;
    logic                             valid;
    logic                             ready;
    logic [tga_rle_pkg::PIXEL_W-1:0]  pixel_value;
    logic [tga_rle_pkg::COUNT_W-1:0]  repeat_count;
    logic                             image_done;

    modport source (output valid, output pixel_value, output repeat_count,
                    output image_done, input ready);
    modport sink   (input valid, input pixel_value, input repeat_count,
                    input image_done, output ready);
endinterface

// ----- src/tga_rle_cfg.sv -----
// ----------------------------------------------------------------------------
// tga_rle_cfg
// apb register file: pixel size and image size, restart pulse after a write
// ----------------------------------------------------------------------------
module tga_rle_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tga_rle_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tga_rle_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tga_rle_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                 pready,
    output tga_rle_pkg::cfg_t                    cfg
);

    logic [tga_rle_pkg::PB_W-1:0]    pixel_bytes_reg;
    logic [tga_rle_pkg::TOTAL_W-1:0] total_pixels_reg;
    logic                            restart_reg;
    logic                            wr_en;
    tga_rle_pkg::reg_sel_t           sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = tga_rle_pkg::reg_sel_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_bytes_reg  <= tga_rle_pkg::PIXEL_BYTES_RESET;
            total_pixels_reg <= tga_rle_pkg::TOTAL_PIXELS_RESET;
            restart_reg      <= 1'b0;
        end
        else
        begin
            restart_reg <= wr_en;
            if (wr_en)
            begin
                unique case (sel)
                    tga_rle_pkg::REG_PIXEL_BYTES:
                        pixel_bytes_reg <= pwdata[tga_rle_pkg::PB_W-1:0];
                    tga_rle_pkg::REG_TOTAL_PIXELS:
                        total_pixels_reg <= pwdata[tga_rle_pkg::TOTAL_W-1:0];
                    default:
                        pixel_bytes_reg <= pixel_bytes_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (sel)
            tga_rle_pkg::REG_PIXEL_BYTES:
                prdata = {{(tga_rle_pkg::APB_DATA_W-tga_rle_pkg::PB_W){1'b0}},
                          pixel_bytes_reg};
            tga_rle_pkg::REG_TOTAL_PIXELS:
                prdata = total_pixels_reg;
            default:
                prdata = '0;
        endcase
    end

    assign cfg.restart      = restart_reg;
    assign cfg.pixel_bytes  = pixel_bytes_reg;
    assign cfg.total_pixels = total_pixels_reg;

endmodule

// ----- src/tga_rle_core.sv -----
// ----------------------------------------------------------------------------
// tga_rle_core
// input byte register, packet/pixel state update and result register
// ----------------------------------------------------------------------------
module tga_rle_core
#(
    parameter int unsigned MAX_PIXEL_BYTES = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tga_rle_pkg::cfg_t     cfg,
    tga_rle_in_if.sink            in_ch,
    tga_rle_out_if.source         out_ch
);

    localparam int unsigned POS_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int unsigned ASM_W = 8 * MAX_PIXEL_BYTES;
    localparam logic [tga_rle_pkg::PB_W-1:0] MAX_PB =
        tga_rle_pkg::PB_W'(MAX_PIXEL_BYTES);

    // input register
    logic                              in_valid_reg,  in_valid_next;
    logic [tga_rle_pkg::BYTE_W-1:0]    in_byte_reg;

    // decoder state
    tga_rle_pkg::phase_t               phase_reg,     phase_next;
    logic [tga_rle_pkg::COUNT_W-1:0]   packet_left_reg, packet_left_next;
    logic [POS_W-1:0]                  pos_reg,       pos_next;
    logic [ASM_W-1:0]                  asm_reg,       asm_next;
    logic [tga_rle_pkg::TOTAL_W-1:0]   pixels_left_reg, pixels_left_next;

    // result register
    logic                              out_valid_reg, out_valid_next;
    logic [tga_rle_pkg::PIXEL_W-1:0]   pixel_reg,     pixel_next;
    logic [tga_rle_pkg::COUNT_W-1:0]   rep_reg,       rep_next;
    logic                              done_reg,      done_next;

    logic                              out_free;
    logic                              proc;
    logic                              res_valid;
    logic [tga_rle_pkg::PB_W-1:0]      eff_pb;
    logic [ASM_W-1:0]                  asm_merged;
    logic                              pix_complete;
    logic [tga_rle_pkg::TOTAL_W-1:0]   rep_wide;
    logic [tga_rle_pkg::TOTAL_W-1:0]   packet_wide;
    logic [tga_rle_pkg::TOTAL_W-1:0]   left_after;

    assign out_free     = !out_valid_reg || out_ch.ready;
    assign proc         = in_valid_reg && out_free;
    assign in_ch.ready  = !in_valid_reg || out_free;

    always_comb
    begin
        if (cfg.pixel_bytes == '0)
            eff_pb = tga_rle_pkg::PB_W'(1);
        else if (cfg.pixel_bytes > MAX_PB)
            eff_pb = MAX_PB;
        else
            eff_pb = cfg.pixel_bytes;
    end

    always_comb
    begin
        asm_merged = asm_reg;
        for (int i = 0; i < MAX_PIXEL_BYTES; i++)
        begin
            if (pos_reg == POS_W'(i))
                asm_merged[8*i +: 8] = in_byte_reg;
        end
    end

    assign pix_complete = ({1'b0, pos_reg} + (POS_W+1)'(1)) >= (POS_W+1)'(eff_pb);
    assign packet_wide  = {{(tga_rle_pkg::TOTAL_W-tga_rle_pkg::COUNT_W){1'b0}},
                           packet_left_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        packet_left_next = packet_left_reg;
        pos_next         = pos_reg;
        asm_next         = asm_reg;
        pixels_left_next = pixels_left_reg;
        res_valid        = 1'b0;
        rep_wide         = '0;
        left_after       = pixels_left_reg;
        pixel_next       = tga_rle_pkg::PIXEL_W'(asm_merged);
        rep_next         = '0;
        done_next        = 1'b0;

        if (phase_reg == tga_rle_pkg::PH_DONE || pixels_left_reg == '0)
        begin
            phase_next = tga_rle_pkg::PH_DONE;
        end
        else if (phase_reg == tga_rle_pkg::PH_HEADER)
        begin
            packet_left_next = (in_byte_reg & tga_rle_pkg::HDR_COUNT_MASK)
                               + tga_rle_pkg::COUNT_W'(1);
            pos_next         = '0;
            asm_next         = '0;
            phase_next       = ((in_byte_reg & tga_rle_pkg::HDR_RUN_FLAG) != '0)
                               ? tga_rle_pkg::PH_RUN : tga_rle_pkg::PH_RAW;
        end
        else if (!pix_complete)
        begin
            pos_next = pos_reg + POS_W'(1);
            asm_next = asm_merged;
        end
        else
        begin
            pos_next  = '0;
            asm_next  = '0;
            res_valid = 1'b1;
            if (phase_reg == tga_rle_pkg::PH_RUN)
            begin
                rep_wide         = (packet_wide > pixels_left_reg) ? pixels_left_reg
                                                                   : packet_wide;
                packet_left_next = '0;
                phase_next       = tga_rle_pkg::PH_HEADER;
            end
            else
            begin
                rep_wide         = tga_rle_pkg::TOTAL_W'(1);
                packet_left_next = packet_left_reg - tga_rle_pkg::COUNT_W'(1);
                if (packet_left_next == '0)
                    phase_next = tga_rle_pkg::PH_HEADER;
            end
            left_after       = pixels_left_reg - rep_wide;
            pixels_left_next = left_after;
            if (left_after == '0)
                phase_next = tga_rle_pkg::PH_DONE;
            rep_next  = rep_wide[tga_rle_pkg::COUNT_W-1:0];
            done_next = (left_after == '0);
        end
    end

    always_comb
    begin
        if (in_ch.valid && in_ch.ready)
            in_valid_next = 1'b1;
        else if (proc)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (proc && res_valid)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= tga_rle_pkg::PH_DONE;
            packet_left_reg <= '0;
            pos_reg         <= '0;
            asm_reg         <= '0;
            pixels_left_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.restart)
            begin
                packet_left_reg <= '0;
                pos_reg         <= '0;
                asm_reg         <= '0;
                pixels_left_reg <= cfg.total_pixels;
                phase_reg       <= (cfg.total_pixels == '0) ? tga_rle_pkg::PH_DONE
                                                            : tga_rle_pkg::PH_HEADER;
            end
            else if (proc)
            begin
                phase_reg       <= phase_next;
                packet_left_reg <= packet_left_next;
                pos_reg         <= pos_next;
                asm_reg         <= asm_next;
                pixels_left_reg <= pixels_left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            in_byte_reg <= in_ch.in_byte;
        if (proc && res_valid)
        begin
            pixel_reg <= pixel_next;
            rep_reg   <= rep_next;
            done_reg  <= done_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.pixel_value  = pixel_reg;
    assign out_ch.repeat_count = rep_reg;
    assign out_ch.image_done   = done_reg;

endmodule

// ----- src/tga_rle_packet_decoder.sv -----
// ----------------------------------------------------------------------------
// tga_rle_packet_decoder
// run-length tga pixel stream decoder, unless the result side stalls, one compressed byte per cycle
// ----------------------------------------------------------------------------
// Takes one byte of run-length TGA pixel data per clock unless the result
// side stalls, and returns at most one pixel result per byte: the packed
// pixel, its repeat count (clipped to the pixels left) and a done flag on the
// result that fills the image. Bytes go through one input register and one
// result register, and a new byte is taken every cycle as long as the result
// side keeps up; the packet and pixel state is updated once per byte. Writing
// either register over APB restarts decoding with the new pixel size and
// image size; bytes after the image is full, or with an image size of zero,
// are taken and dropped.
module tga_rle_packet_decoder
#(
    parameter int unsigned MAX_PIXEL_BYTES = 4
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    tga_rle_in_if.sink                           in_ch,
    tga_rle_out_if.source                        out_ch,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tga_rle_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tga_rle_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tga_rle_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                 pready
);

    tga_rle_pkg::cfg_t cfg;

    tga_rle_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tga_rle_core
    #(
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    )
    u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule
